### rtl/nrmc_pkg.sv
// Shared definitions for the NMEA RMC sentence checker.
// Holds the field count limit, the parser phase type and the result record.
// No dependencies.
package nrmc_pkg;

  localparam int FIELD_SLOTS = 20;

  localparam logic [4:0] COMMA_LIMIT = 5'(FIELD_SLOTS - 1);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_HEX_HI = 4'b0100,
    PH_HEX_LO = 4'b1000
  } nrmc_phase_t;

  typedef struct packed {
    logic       sentence_valid;
    logic       is_rmc;
    logic       checksum_match;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [4:0] comma_count;
    logic       hex_error;
  } nrmc_result_t;

  typedef struct packed {
    nrmc_phase_t phase;
    logic        result_valid;
  } nrmc_status_t;

endpackage

### rtl/nrmc_if.sv
// Valid/ready channel interfaces for the received byte stream and the results.
// Depends on nrmc_pkg for nothing but sits after it in compile order.
interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  logic       valid;
  logic       ready;
  logic       sentence_valid;
  logic       is_rmc;
  logic       checksum_match;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic [4:0] comma_count;
  logic       hex_error;

  modport source (output valid, output sentence_valid, output is_rmc,
                  output checksum_match, output computed_sum, output received_sum,
                  output comma_count, output hex_error, input ready);
  modport sink   (input valid, input sentence_valid, input is_rmc,
                  input checksum_match, input computed_sum, input received_sum,
                  input comma_count, input hex_error, output ready);
endinterface

### rtl/nmea_rmc_sentence_checker_top.sv
// Top level of the NMEA RMC sentence checker: parser plus a two-entry output
// buffer. Depends on nrmc_pkg, nrmc_if and nrmc_parser.
// Each result is registered into the output entry, or the skid entry on a stall.
// Throughput: one byte per cycle while the skid entry is empty; the output
// buffer and skid entry let the parser take bytes for one result while stalled.
// Reset (synchronous, rst high): parser idle waiting for a dollar, buffer empty.
module nmea_rmc_sentence_checker_top
  import nrmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  nrmc_in_if.sink           rx_ch,
  nrmc_out_if.source        res_ch
);

  nrmc_result_t result;
  nrmc_status_t status;
  nrmc_result_t out_data, skid_data;
  logic         out_valid, skid_valid;
  logic         accept;
  logic         drain;

  assign rx_ch.ready = ~skid_valid;
  assign accept      = rx_ch.valid & rx_ch.ready;
  assign drain       = out_valid & res_ch.ready;

  nrmc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_ch.rx_byte),
    .result  (result),
    .status  (status)
  );

  // A new result can only arrive while the skid entry is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (status.result_valid) begin
      if (!out_valid || drain) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end else if (drain) begin
      out_valid  <= skid_valid;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end
  end

  assign res_ch.valid          = out_valid;
  assign res_ch.sentence_valid = out_data.sentence_valid;
  assign res_ch.is_rmc         = out_data.is_rmc;
  assign res_ch.checksum_match = out_data.checksum_match;
  assign res_ch.computed_sum   = out_data.computed_sum;
  assign res_ch.received_sum   = out_data.received_sum;
  assign res_ch.comma_count    = out_data.comma_count;
  assign res_ch.hex_error      = out_data.hex_error;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output entry empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !res_ch.ready))
    else $error("skid entry filled without an output stall");

  a_dollar_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && rx_ch.rx_byte == CHAR_DOLLAR) |=> (status.phase == PH_BODY))
    else $error("dollar transfer did not restart the sentence");
`endif

endmodule

### rtl/nrmc_parser.sv
// Sentence parser: holds the per-sentence state and forms a result on the
// second checksum digit. Depends on nrmc_pkg.
module nrmc_parser
  import nrmc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   rx_byte,
  output nrmc_result_t result,
  output nrmc_status_t status
);

  nrmc_phase_t phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [2:0]  header_pos, header_pos_next;
  logic        header_ok, header_ok_next;
  logic [4:0]  comma_total, comma_total_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        digit_bad, digit_bad_next;

  logic [4:0]  digit;
  logic [7:0]  recv;
  logic        bad_all;
  logic        match;

  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h47;  // G
      3'd1:    ch = 8'h50;  // P
      3'd2:    ch = 8'h52;  // R
      3'd3:    ch = 8'h4D;  // M
      default: ch = 8'h43;  // C
    endcase
    return ch;
  endfunction

  // Upper bit flags a character that is not a hex digit; its value is then zero.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

  assign digit   = hex_decode(rx_byte);
  assign recv    = {high_nibble, digit[3:0]};
  assign bad_all = digit_bad | digit[4];
  assign match   = (recv == running_xor);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    header_pos_next  = header_pos;
    header_ok_next   = header_ok;
    comma_total_next = comma_total;
    high_nibble_next = high_nibble;
    digit_bad_next   = digit_bad;
    if (rx_byte == CHAR_DOLLAR) begin
      phase_next       = PH_BODY;
      running_xor_next = '0;
      header_pos_next  = '0;
      header_ok_next   = 1'b1;
      comma_total_next = '0;
      high_nibble_next = '0;
      digit_bad_next   = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_BODY: begin
          if (rx_byte == CHAR_STAR) begin
            if (header_pos < 3'd5) header_ok_next = 1'b0;
            phase_next = PH_HEX_HI;
          end else begin
            running_xor_next = running_xor ^ rx_byte;
            if (header_pos < 3'd5) begin
              if (rx_byte != header_char(header_pos)) header_ok_next = 1'b0;
              header_pos_next = header_pos + 3'd1;
            end
            if (rx_byte == CHAR_COMMA && comma_total < COMMA_LIMIT) begin
              comma_total_next = comma_total + 5'd1;
            end
          end
        end
        PH_HEX_HI: begin
          high_nibble_next = digit[3:0];
          digit_bad_next   = digit_bad | digit[4];
          phase_next       = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          digit_bad_next = bad_all;
          phase_next     = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      running_xor <= '0;
      header_pos  <= '0;
      header_ok   <= 1'b0;
      comma_total <= '0;
      high_nibble <= '0;
      digit_bad   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      header_pos  <= header_pos_next;
      header_ok   <= header_ok_next;
      comma_total <= comma_total_next;
      high_nibble <= high_nibble_next;
      digit_bad   <= digit_bad_next;
    end
  end

  assign result.sentence_valid = header_ok & match & ~bad_all;
  assign result.is_rmc         = header_ok;
  assign result.checksum_match = match;
  assign result.computed_sum   = running_xor;
  assign result.received_sum   = recv;
  assign result.comma_count    = comma_total;
  assign result.hex_error      = bad_all;

  assign status.phase        = phase;
  assign status.result_valid = accept && (phase == PH_HEX_LO) && (rx_byte != CHAR_DOLLAR);

endmodule
